FILE: src/talu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package talu_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned OpW   = 4;

  // Operation codes; 12 to 15 are no-ops
  typedef enum logic [OpW-1:0] {
    OP_ADD = 4'd0,
    OP_ADC = 4'd1,
    OP_SUB = 4'd2,
    OP_SBC = 4'd3,
    OP_CMP = 4'd4,
    OP_CMN = 4'd5,
    OP_AND = 4'd6,
    OP_EOR = 4'd7,
    OP_ORR = 4'd8,
    OP_TST = 4'd9,
    OP_MUL = 4'd10,
    OP_MOV = 4'd11
  } alu_op_t;

  // Stored condition flags
  typedef struct packed {
    logic n;
    logic z;
    logic c;
    logic v;
  } nzcv_t;

  typedef struct packed {
    logic [OpW-1:0]   op;
    logic [DataW-1:0] operand_a;
    logic [DataW-1:0] operand_b;
  } op_item_t;

  typedef struct packed {
    logic [DataW-1:0] result_value;
    logic             writes_back;
    logic             neg_flag;
    logic             zero_flag;
    logic             carry_flag;
    logic             overflow_flag;
  } res_item_t;

endpackage

`default_nettype wire

FILE: src/talu_exec.sv
`timescale 1ns / 1ps
`default_nettype none

module talu_exec
  import talu_pkg::*;
(
  input  op_item_t  item,
  input  nzcv_t     flags,
  output res_item_t res,
  output nzcv_t     flags_next
);

  logic [DataW-1:0] a;
  logic [DataW-1:0] b;
  logic [DataW-1:0] b_sel;
  logic             cin;
  logic [DataW:0]   sum;
  logic [DataW-1:0] sum_r;
  logic             add_v;
  logic [DataW-1:0] r;
  logic             wb;
  logic             is_arith;
  logic             known;

  assign a = item.operand_a;
  assign b = item.operand_b;

  // Adder operand and carry-in select; subtraction is a + ~b + cin
  always_comb begin
    b_sel = b;
    cin   = 1'b0;
    case (item.op)
      OP_ADC: cin = flags.c;
      OP_SUB, OP_CMP: begin
        b_sel = ~b;
        cin   = 1'b1;
      end
      OP_SBC: begin
        b_sel = ~b;
        cin   = flags.c;
      end
      default: begin
        b_sel = b;
        cin   = 1'b0;
      end
    endcase
  end

  assign sum   = {1'b0, a} + {1'b0, b_sel} + {{DataW{1'b0}}, cin};
  assign sum_r = sum[DataW-1:0];
  assign add_v = (a[DataW-1] ^ sum_r[DataW-1]) & (b_sel[DataW-1] ^ sum_r[DataW-1]);

  // Result mux
  always_comb begin
    r        = '0;
    wb       = 1'b1;
    is_arith = 1'b0;
    known    = 1'b1;
    unique case (item.op)
      OP_ADD, OP_ADC, OP_SUB, OP_SBC: begin
        r        = sum_r;
        is_arith = 1'b1;
      end
      OP_CMP, OP_CMN: begin
        r        = sum_r;
        wb       = 1'b0;
        is_arith = 1'b1;
      end
      OP_AND: r = a & b;
      OP_EOR: r = a ^ b;
      OP_ORR: r = a | b;
      OP_TST: begin
        r  = a & b;
        wb = 1'b0;
      end
      OP_MUL: r = a * b;
      OP_MOV: r = a;
      default: begin
        r     = '0;
        wb    = 1'b0;
        known = 1'b0;
      end
    endcase
  end

  // Flag update: logical ops, MUL and MOV keep C and V, no-ops keep everything
  always_comb begin
    flags_next = flags;
    if (known) begin
      flags_next.n = r[DataW-1];
      flags_next.z = (r == '0);
      if (is_arith) begin
        flags_next.c = sum[DataW];
        flags_next.v = add_v;
      end
    end
  end

  assign res.result_value  = r;
  assign res.writes_back   = wb;
  assign res.neg_flag      = flags_next.n;
  assign res.zero_flag     = flags_next.z;
  assign res.carry_flag    = flags_next.c;
  assign res.overflow_flag = flags_next.v;

endmodule

`default_nettype wire

FILE: src/thumb_alu_with_flags.sv
// ALU with stored NZCV flags.
// Each item passes through the input register, then the result register.
// Throughput: one item per cycle while res_stall is low; the flag register feeds the next
// item's carry through the combinational adder path between the two registers.
// Reset (rst, synchronous, active high) clears both valid bits and the flags.
`timescale 1ns / 1ps
`default_nettype none

module thumb_alu_with_flags
  import talu_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      op_valid,
  output logic           op_stall,
  input  wire op_item_t  op_item,
  output logic           res_valid,
  input  wire logic      res_stall,
  output res_item_t      res_item
);

  logic      hold_valid;
  op_item_t  hold_item;
  nzcv_t     flags;
  nzcv_t     flags_next;
  res_item_t exec_res;
  logic      advance;

  // Result register can take a new item when empty or being drained
  assign advance  = !res_valid || !res_stall;
  assign op_stall = hold_valid && !advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (!op_stall) begin
      hold_valid <= op_valid;
    end
    if (!op_stall) begin
      hold_item <= op_item;
    end
  end

  talu_exec u_exec (
    .item       (hold_item),
    .flags      (flags),
    .res        (exec_res),
    .flags_next (flags_next)
  );

  // Result register and flag state
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      flags     <= '0;
    end else if (advance) begin
      res_valid <= hold_valid;
      if (hold_valid) begin
        flags <= flags_next;
      end
    end
    if (advance && hold_valid) begin
      res_item <= exec_res;
    end
  end

  // Stored flags always match the flags reported with the waiting result
  a_flags_match: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (flags == {res_item.neg_flag, res_item.zero_flag,
                             res_item.carry_flag, res_item.overflow_flag}))
    else $error("flag register differs from reported flags");

  // A written-back result carries a consistent Z flag
  a_zero_flag: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_item.writes_back) |->
      (res_item.zero_flag == (res_item.result_value == '0)))
    else $error("zero flag inconsistent with result");

  // Input stalls only when an item is held
  a_stall_held: assert property (@(posedge clk) disable iff (rst)
    op_stall |-> hold_valid)
    else $error("stall without held item");

  // Flags stay put while no item moves into the result register
  a_flags_stable: assert property (@(posedge clk) disable iff (rst)
    !(advance && hold_valid) |=> $stable(flags))
    else $error("flags changed without an item");

endmodule

`default_nettype wire

FILE: bench/tb.sv
`timescale 1ns / 1ps

module tb;
  import talu_pkg::*;

  // Opcodes past MOV decode to no-op
  localparam logic [OpW-1:0] OP_UNUSED_FIRST = 4'd12;
  localparam logic [OpW-1:0] OP_UNUSED_LAST  = 4'd15;

  localparam int RandomItems = 1000;
  localparam int CycleLimit  = 200000;
  localparam int DrainCycles = 10;

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      op_valid  = 1'b0;
  logic      op_stall;
  op_item_t  op_item   = '0;
  logic      res_valid;
  logic      res_stall = 1'b0;
  res_item_t res_item;

  thumb_alu_with_flags DUT (
    .clk       (clk),
    .rst       (rst),
    .op_valid  (op_valid),
    .op_stall  (op_stall),
    .op_item   (op_item),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_item  (res_item)
  );

  always #10 clk = ~clk;

  // Predicted flag register, advanced as each item is accepted
  nzcv_t     alu_flags = '0;
  res_item_t expected_results[$];
  int        errors     = 0;
  int        cycles     = 0;
  bit        no_idle    = 1'b0;
  int        stall_left = 0;

  // Expected result of one item; updates the predicted flags
  function automatic res_item_t predict_result(input logic [OpW-1:0]   op,
                                               input logic [DataW-1:0] a,
                                               input logic [DataW-1:0] b);
    res_item_t        res;
    logic [DataW-1:0] addend;
    logic [DataW:0]   wide;
    logic             cin;
    logic             arith;
    logic             valid;
    res             = '0;
    res.writes_back = 1'b1;
    addend          = b;
    cin             = 1'b0;
    arith           = 1'b0;
    valid           = 1'b1;
    case (op)
      OP_ADD: arith = 1'b1;
      OP_ADC: begin
        arith = 1'b1;
        cin   = alu_flags.c;
      end
      OP_SUB: begin
        arith  = 1'b1;
        addend = ~b;
        cin    = 1'b1;
      end
      OP_SBC: begin
        arith  = 1'b1;
        addend = ~b;
        cin    = alu_flags.c;
      end
      OP_CMP: begin
        arith           = 1'b1;
        addend          = ~b;
        cin             = 1'b1;
        res.writes_back = 1'b0;
      end
      OP_CMN: begin
        arith           = 1'b1;
        res.writes_back = 1'b0;
      end
      OP_AND: res.result_value = a & b;
      OP_EOR: res.result_value = a ^ b;
      OP_ORR: res.result_value = a | b;
      OP_TST: begin
        res.result_value = a & b;
        res.writes_back  = 1'b0;
      end
      OP_MUL: res.result_value = a * b;
      OP_MOV: res.result_value = a;
      default: begin
        valid           = 1'b0;
        res.writes_back = 1'b0;
      end
    endcase
    // C is carry out (no borrow on subtract); V is signed overflow
    if (arith) begin
      wide             = {1'b0, a} + {1'b0, addend} + {{DataW{1'b0}}, cin};
      res.result_value = wide[DataW-1:0];
      alu_flags.c      = wide[DataW];
      alu_flags.v      = (a[DataW-1] ^ wide[DataW-1]) & (addend[DataW-1] ^ wide[DataW-1]);
    end
    if (valid) begin
      alu_flags.n = res.result_value[DataW-1];
      alu_flags.z = (res.result_value == '0);
    end
    res.neg_flag      = alu_flags.n;
    res.zero_flag     = alu_flags.z;
    res.carry_flag    = alu_flags.c;
    res.overflow_flag = alu_flags.v;
    return res;
  endfunction

  // Send one item after a random gap; hold it until accepted
  task automatic send_op(input logic [OpW-1:0]   op,
                         input logic [DataW-1:0] a,
                         input logic [DataW-1:0] b);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      op_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    op_valid <= 1'b1;
    op_item  <= '{op: op, operand_a: a, operand_b: b};
    do @(posedge clk); while (op_stall);
    expected_results.push_back(predict_result(op, a, b));
  endtask

  task automatic check_result(input res_item_t got, input res_item_t want);
    if (got.result_value !== want.result_value) begin
      $error("result_value: expected %h, got %h", want.result_value, got.result_value);
      errors++;
    end
    if (got.writes_back !== want.writes_back) begin
      $error("writes_back: expected %b, got %b", want.writes_back, got.writes_back);
      errors++;
    end
    if (got.neg_flag !== want.neg_flag) begin
      $error("neg_flag: expected %b, got %b", want.neg_flag, got.neg_flag);
      errors++;
    end
    if (got.zero_flag !== want.zero_flag) begin
      $error("zero_flag: expected %b, got %b", want.zero_flag, got.zero_flag);
      errors++;
    end
    if (got.carry_flag !== want.carry_flag) begin
      $error("carry_flag: expected %b, got %b", want.carry_flag, got.carry_flag);
      errors++;
    end
    if (got.overflow_flag !== want.overflow_flag) begin
      $error("overflow_flag: expected %b, got %b", want.overflow_flag, got.overflow_flag);
      errors++;
    end
  endtask

  // Result side: check each accepted item, then draw a random stall unless no_idle is set
  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) begin
      if (expected_results.size() == 0) begin
        $error("result_value %h arrived with no item pending", res_item.result_value);
        errors++;
      end else begin
        check_result(res_item, expected_results.pop_front());
      end
      stall_left = no_idle ? 0 : $urandom_range(0, 3);
    end else if (stall_left > 0) begin
      stall_left--;
    end
    res_stall <= (stall_left > 0);
  end

  // Run watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Operands weighted toward the carry and overflow corners
  function automatic logic [DataW-1:0] pick_operand();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h8000_0000;
      3:       return 32'h7FFF_FFFF;
      4:       return $urandom_range(0, 15);
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [OpW-1:0] pick_op();
    if ($urandom_range(0, 19) == 0) begin
      return OpW'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));
    end
    return OpW'($urandom_range(OP_ADD, OP_MOV));
  endfunction

  // Add and subtract corners, carry in from the stored C
  task automatic test_arith_edges();
    send_op(OP_ADC, '0, '0);                    // flags clear after reset
    send_op(OP_ADD, 32'h7FFF_FFFF, 32'd1);      // signed overflow
    send_op(OP_ADD, 32'hFFFF_FFFF, 32'd1);      // carry out, zero
    send_op(OP_ADC, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_op(OP_SUB, 32'd5, '0);                 // no borrow for zero subtrahend
    send_op(OP_SUB, '0, 32'd1);                 // borrow
    send_op(OP_SBC, 32'd10, 32'd3);             // C clear: one extra taken off
    send_op(OP_CMP, 32'h8000_0000, 32'd1);      // overflow, no write back
    send_op(OP_SBC, 32'd10, 32'd3);             // C set
    send_op(OP_CMN, 32'hFFFF_FFFF, 32'd1);
    send_op(OP_CMP, 32'd7, 32'd7);
  endtask

  // Logical ops, MUL and MOV must leave C and V alone
  task automatic test_logic_keeps_cv();
    send_op(OP_ADD, 32'h8000_0000, 32'h8000_0000);  // sets C and V
    send_op(OP_AND, 32'hFFFF_FFFF, 32'h0F0F_0F0F);
    send_op(OP_EOR, 32'hA5A5_A5A5, 32'hA5A5_A5A5);
    send_op(OP_ORR, 32'h8000_0000, 32'd1);
    send_op(OP_TST, 32'h0000_00F0, 32'h0000_000F);
    send_op(OP_MUL, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_op(OP_MUL, 32'h0001_0000, 32'h0001_0000);  // product wraps to zero
    send_op(OP_MOV, 32'h8000_0000, $urandom());
  endtask

  // Unused opcodes report the stored flags and change nothing
  task automatic test_unused_ops();
    for (int code = OP_UNUSED_FIRST; code <= OP_UNUSED_LAST; code++) begin
      send_op(code[OpW-1:0], $urandom(), $urandom());
    end
  endtask

  // Random items in segments; some segments run with no idling at all
  task automatic test_random_ops();
    bit               is_sub;
    logic [DataW-1:0] a_hi;
    logic [DataW-1:0] b_hi;
    for (int seg = 0; seg < 10; seg++) begin
      no_idle = (seg % 4 == 3);
      for (int i = 0; i < RandomItems / 10; i++) begin
        if ($urandom_range(0, 4) == 0) begin
          // Two-word add or subtract: low word, then high word with carry
          is_sub = 1'($urandom_range(0, 1));
          a_hi   = pick_operand();
          b_hi   = pick_operand();
          send_op(is_sub ? OP_SUB : OP_ADD, pick_operand(), pick_operand());
          send_op(is_sub ? OP_SBC : OP_ADC, a_hi, b_hi);
        end else begin
          send_op(pick_op(), pick_operand(), pick_operand());
        end
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_arith_edges();
    test_logic_keeps_cv();
    test_unused_ops();
    test_random_ops();
    op_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
